### rtl/kmd_pkg.sv
package kmd_pkg;

  localparam int ROW_IDX_W   = 3;
  localparam int COL_IDX_W   = 5;
  localparam int PIN_W       = 20;
  localparam int SCAN_W      = 8;
  localparam int ROWS_DEF    = 8;
  localparam int COLS_DEF    = 20;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [SCAN_W-1:0] SETTLE_RESET = 8'd5;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic REG_SETTLE_SCANS = 1'b0;

  typedef struct packed {
    logic                 cmd;
    logic [ROW_IDX_W-1:0] row_index;
    logic [COL_IDX_W-1:0] column_index;
    logic [PIN_W-1:0]     pin_levels;
    logic                 end_of_scan;
  } item_t;

  typedef struct packed {
    logic [PIN_W-1:0] stable_row;
    logic             key_on;
    logic             settling;
    logic             committed;
  } result_t;

endpackage

### rtl/key_matrix_debouncer.sv
// channel | handshake                | word
// in      | in_valid / in_ready      | cmd, row_index, column_index, pin_levels, end_of_scan
// out     | out_valid / out_ready    | stable_row, key_on, settling, committed
// cfg     | psel, penable, pwrite    | paddr, pwdata, prdata (settle_scans at 0x0)
// One word per cycle while the output is not stalled; a word passes the input register, then the
// row compare, counter update and matrix copy into the result register.
// Reset clears pending and stable matrices and loads the settle count with 5.
// A stalled output holds its word; the input register then takes at most one more
// word and holds it until the result register drains.
module key_matrix_debouncer #(
  parameter int ROWS = kmd_pkg::ROWS_DEF,
  parameter int COLS = kmd_pkg::COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [kmd_pkg::ROW_IDX_W-1:0]   in_row_index,
  input  logic [kmd_pkg::COL_IDX_W-1:0]   in_column_index,
  input  logic [kmd_pkg::PIN_W-1:0]       in_pin_levels,
  input  logic                            in_end_of_scan,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kmd_pkg::PIN_W-1:0]       out_stable_row,
  output logic                            out_key_on,
  output logic                            out_settling,
  output logic                            out_committed,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kmd_pkg::PADDR_W-1:0]     paddr,
  input  logic [kmd_pkg::PDATA_W-1:0]     pwdata,
  output logic [kmd_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import kmd_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  item_t             s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_word_r;
  result_t           core_result;
  logic              step;
  logic [SCAN_W-1:0] settle_scans_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SETTLE_SCANS);
  assign prdata = (paddr[2] == REG_SETTLE_SCANS) ?
                  PDATA_W'(settle_scans_r) : '0;

  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;

  always_comb begin
    s1_valid_nxt  = (in_valid && in_ready) ? 1'b1 : (step ? 1'b0 : s1_valid_r);
    out_valid_nxt = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  kmd_core #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (s1_item_r),
    .settle_scans(settle_scans_r),
    .result      (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      settle_scans_r <= SETTLE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        settle_scans_r <= pwdata[SCAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.cmd          <= in_cmd;
      s1_item_r.row_index    <= in_row_index;
      s1_item_r.column_index <= in_column_index;
      s1_item_r.pin_levels   <= in_pin_levels;
      s1_item_r.end_of_scan  <= in_end_of_scan;
    end
    if (step) begin
      out_word_r <= core_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_stable_row = out_word_r.stable_row;
  assign out_key_on     = out_word_r.key_on;
  assign out_settling   = out_word_r.settling;
  assign out_committed  = out_word_r.committed;

  a_commit_ends_settle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.committed |-> !out_word_r.settling)
    else $error("commit reported while still settling");

  a_key_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.key_on |-> out_word_r.stable_row != '0)
    else $error("key on in an empty stable row");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !step |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register lost a stalled word");

endmodule

### rtl/kmd_core.sv
module kmd_core #(
  parameter int ROWS = kmd_pkg::ROWS_DEF,
  parameter int COLS = kmd_pkg::COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  kmd_pkg::item_t               item,
  input  logic [kmd_pkg::SCAN_W-1:0]   settle_scans,
  output kmd_pkg::result_t             result
);
  import kmd_pkg::*;

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [PIN_W-1:0] ColMask =
    (COLS >= PIN_W) ? {PIN_W{1'b1}} : PIN_W'((64'd1 << COLS) - 64'd1);

  logic [PIN_W-1:0]  pending_r [ROWS];
  logic [PIN_W-1:0]  stable_r  [ROWS];
  logic [PIN_W-1:0]  pending_nxt [ROWS];
  logic [PIN_W-1:0]  stable_nxt  [ROWS];
  logic [SCAN_W-1:0] count_r, count_nxt, count_ld;

  logic [31:0]       row_ext;
  logic [RW-1:0]     row_sel;
  logic              row_ok, col_ok, is_sample, differ, dec, commit;
  logic [PIN_W-1:0]  pressed, srow;

  always_comb begin
    row_ext   = 32'(item.row_index);
    row_sel   = row_ext[RW-1:0];
    row_ok    = row_ext < 32'(ROWS);
    col_ok    = (32'(item.column_index) < 32'(COLS)) &&
                (32'(item.column_index) < 32'(PIN_W));
    is_sample = item.cmd == CMD_SAMPLE;
    pressed   = ~item.pin_levels & ColMask;
    differ    = is_sample && row_ok && (pending_r[row_sel] != pressed);
    count_ld  = differ ? settle_scans : count_r;
    dec       = is_sample && item.end_of_scan && (count_ld != '0);
    count_nxt = dec ? count_ld - SCAN_W'(1) : count_ld;
    commit    = dec && (count_nxt == '0);
    for (int r = 0; r < ROWS; r++) begin
      pending_nxt[r] = (differ && row_sel == RW'(r)) ? pressed : pending_r[r];
      stable_nxt[r]  = commit ? pending_nxt[r] : stable_r[r];
    end
    if (!row_ok) begin
      srow = '0;
    end else if (commit) begin
      srow = pressed;
    end else begin
      srow = stable_r[row_sel];
    end
    result.stable_row = srow;
    result.key_on     = col_ok && srow[item.column_index];
    result.settling   = count_nxt != '0;
    result.committed  = commit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= SETTLE_RESET;
      for (int r = 0; r < ROWS; r++) begin
        pending_r[r] <= '0;
        stable_r[r]  <= '0;
      end
    end else if (step) begin
      count_r <= count_nxt;
      for (int r = 0; r < ROWS; r++) begin
        pending_r[r] <= pending_nxt[r];
        stable_r[r]  <= stable_nxt[r];
      end
    end
  end

endmodule

### dv/tb_key_matrix_debouncer.sv
module tb_key_matrix_debouncer;
  timeunit 1ns;
  timeprecision 1ps;

  import kmd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 120;
  localparam int PRINT_CAP      = 200;
  localparam int ITEM_W         = $bits(item_t);

  class debounce_tracker;
    logic [PIN_W-1:0]  pending_keys [ROWS_DEF];
    logic [PIN_W-1:0]  stable_keys [ROWS_DEF];
    logic [SCAN_W-1:0] settle_left;
    logic [SCAN_W-1:0] settle_setting;
    logic [PIN_W-1:0]  col_mask;
    result_t           queued_results[$];
    int                errors;
    int                words_seen;

    function new();
      for (int r = 0; r < ROWS_DEF; r++) begin
        pending_keys[r] = '0;
        stable_keys[r]  = '0;
      end
      for (int i = 0; i < PIN_W; i++) begin
        col_mask[i] = (i < COLS_DEF);
      end
      settle_setting = SETTLE_RESET;
      settle_left    = SETTLE_RESET;
      errors         = 0;
      words_seen     = 0;
    endfunction

    function void set_settle(logic [SCAN_W-1:0] value);
      settle_setting = value;
    endfunction

    function int outstanding();
      return queued_results.size();
    endfunction

    function void take_word(item_t w);
      result_t          r;
      logic [PIN_W-1:0] pressed;
      r = '0;
      if (w.cmd == CMD_SAMPLE) begin
        pressed = ~w.pin_levels & col_mask;
        if (int'(w.row_index) < ROWS_DEF && pending_keys[w.row_index] != pressed) begin
          pending_keys[w.row_index] = pressed;
          settle_left = settle_setting;
        end
        if (w.end_of_scan && settle_left != '0) begin
          settle_left = settle_left - 1'b1;
          if (settle_left == '0) begin
            stable_keys = pending_keys;
            r.committed = 1'b1;
          end
        end
      end
      if (int'(w.row_index) < ROWS_DEF) begin
        r.stable_row = stable_keys[w.row_index];
        if (int'(w.column_index) < COLS_DEF) begin
          r.key_on = r.stable_row[w.column_index];
        end
      end
      r.settling = (settle_left != '0);
      queued_results.push_back(r);
    endfunction

    task report(string what);
      if (errors < PRINT_CAP) begin
        $display("mismatch @%0t word %0d: %s", $realtime, words_seen, what);
      end
      errors++;
    endtask

    task check_word(result_t got);
      result_t want;
      words_seen++;
      if (queued_results.size() == 0) begin
        report($sformatf("result word with nothing expected, stable_row %h", got.stable_row));
        return;
      end
      want = queued_results.pop_front();
      if (got.stable_row !== want.stable_row) begin
        report($sformatf("stable_row %h, want %h", got.stable_row, want.stable_row));
      end
      if (got.key_on !== want.key_on) begin
        report($sformatf("key_on %b, want %b", got.key_on, want.key_on));
      end
      if (got.settling !== want.settling) begin
        report($sformatf("settling %b, want %b", got.settling, want.settling));
      end
      if (got.committed !== want.committed) begin
        report($sformatf("committed %b, want %b", got.committed, want.committed));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_cmd;
  logic [ROW_IDX_W-1:0] in_row_index;
  logic [COL_IDX_W-1:0] in_column_index;
  logic [PIN_W-1:0]     in_pin_levels;
  logic                 in_end_of_scan;
  logic                 out_valid;
  logic                 out_ready;
  logic [PIN_W-1:0]     out_stable_row;
  logic                 out_key_on;
  logic                 out_settling;
  logic                 out_committed;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  debounce_tracker  tracker;
  bit               send_gaps;
  bit               recv_stalls;
  bit               long_hold_req;
  int               quiet_cycles;
  logic [PIN_W-1:0] key_hold [ROWS_DEF];

  key_matrix_debouncer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_row_index    (in_row_index),
    .in_column_index (in_column_index),
    .in_pin_levels   (in_pin_levels),
    .in_end_of_scan  (in_end_of_scan),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_stable_row  (out_stable_row),
    .out_key_on      (out_key_on),
    .out_settling    (out_settling),
    .out_committed   (out_committed),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic item_t word_of(logic cmd, int row, int col, logic [PIN_W-1:0] pins,
                                    logic eos);
    item_t w;
    w.cmd          = cmd;
    w.row_index    = ROW_IDX_W'(row);
    w.column_index = COL_IDX_W'(col);
    w.pin_levels   = pins;
    w.end_of_scan  = eos;
    return w;
  endfunction

  task automatic send_word(input item_t w);
    logic ready_now;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= w.cmd;
    in_row_index    <= w.row_index;
    in_column_index <= w.column_index;
    in_pin_levels   <= w.pin_levels;
    in_end_of_scan  <= w.end_of_scan;
    forever begin
      @(negedge clk);
      ready_now = in_ready;
      @(posedge clk);
      if (ready_now) break;
    end
    tracker.take_word(w);
  endtask

  task automatic send_query();
    send_word(word_of(CMD_QUERY, $urandom_range(0, ROWS_DEF - 1), $urandom_range(0, 31),
                      PIN_W'($urandom), 1'($urandom)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settle(input logic [SCAN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(REG_SETTLE_SCANS));
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_settle(value);
  endtask

  task automatic run_scan_phase(input int n_words, input logic [SCAN_W-1:0] setting,
                                input bit gaps, input bit stalls, input bit squeeze);
    int                     sent;
    int                     choice;
    int                     rr;
    int                     cc;
    logic [PIN_W-1:0]       pins;
    logic [ITEM_W-1:0]      raw;
    drain();
    write_settle(setting);
    send_gaps   = gaps;
    recv_stalls = stalls;
    if (squeeze) long_hold_req = 1'b1;
    sent = 0;
    while (sent < n_words) begin
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            rr = $urandom_range(0, ROWS_DEF - 1);
            cc = $urandom_range(0, PIN_W - 1);
            key_hold[rr][cc] = ~key_hold[rr][cc];
          end
        end
        for (int r = 0; r < ROWS_DEF; r++) begin
          pins = ~key_hold[r];
          if ($urandom_range(0, 15) == 0) pins[$urandom_range(0, PIN_W - 1)] ^= 1'b1;
          send_word(word_of(CMD_SAMPLE, r, $urandom_range(0, 31), pins, r == ROWS_DEF - 1));
          sent++;
          if ($urandom_range(0, 5) == 0) begin
            send_query();
            sent++;
          end
        end
      end else if (choice < 9) begin
        send_query();
        sent++;
      end else begin
        raw = ITEM_W'($urandom);
        send_word(raw);
        sent++;
      end
    end
  endtask

  initial begin
    in_valid        <= 1'b0;
    in_cmd          <= CMD_SAMPLE;
    in_row_index    <= '0;
    in_column_index <= '0;
    in_pin_levels   <= '1;
    in_end_of_scan  <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    rst_n           <= 1'b0;
    out_ready       <= 1'b0;
    for (int r = 0; r < ROWS_DEF; r++) key_hold[r] = '0;
    tracker       = new();
    send_gaps     = 1'b1;
    recv_stalls   = 1'b1;
    long_hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(word_of(CMD_QUERY, 0, 0, '0, 1'b1));
    send_word(word_of(CMD_SAMPLE, 0, 0, '0, 1'b0));
    send_word(word_of(CMD_SAMPLE, 7, 31, '1, 1'b0));
    send_word(word_of(CMD_SAMPLE, 3, 5, 20'hAAAAA, 1'b0));
    repeat (5) send_word(word_of(CMD_SAMPLE, 7, 19, '1, 1'b1));
    send_word(word_of(CMD_QUERY, 0, 19, '1, 1'b0));
    send_word(word_of(CMD_QUERY, 0, 20, '0, 1'b0));
    send_word(word_of(CMD_QUERY, 0, 31, '0, 1'b1));
    send_word(word_of(CMD_QUERY, 3, 0, '0, 1'b0));
    send_word(word_of(CMD_QUERY, 3, 1, '0, 1'b0));
    send_word(word_of(CMD_SAMPLE, 0, 0, 20'h55555, 1'b1));

    drain();
    write_settle(8'd0);
    send_word(word_of(CMD_SAMPLE, 1, 0, 20'h12345, 1'b1));
    send_word(word_of(CMD_SAMPLE, 1, 0, 20'h12345, 1'b1));
    send_word(word_of(CMD_QUERY, 1, 2, '0, 1'b0));

    drain();
    write_settle(8'd1);
    send_word(word_of(CMD_SAMPLE, 1, 0, 20'h12345, 1'b1));
    send_word(word_of(CMD_SAMPLE, 1, 0, 20'hEDCBA, 1'b1));
    send_word(word_of(CMD_QUERY, 1, 0, '0, 1'b0));
    send_word(word_of(CMD_QUERY, 0, 1, '0, 1'b0));

    run_scan_phase(115, 8'd3, 1'b1, 1'b1, 1'b1);
    run_scan_phase(115, 8'd255, 1'b1, 1'b0, 1'b0);
    run_scan_phase(115, 8'd0, 1'b0, 1'b1, 1'b0);
    run_scan_phase(115, 8'd2, 1'b1, 1'b1, 1'b0);
    run_scan_phase(115, SCAN_W'($urandom_range(4, 12)), 1'b1, 1'b1, 1'b1);
    run_scan_phase(115, 8'd1, 1'b0, 1'b0, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (tracker.outstanding() != 0) begin
      tracker.report($sformatf("%0d result words never arrived", tracker.outstanding()));
    end
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_word({out_stable_row, out_key_on, out_settling, out_committed});
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

### filelist.f
rtl/kmd_pkg.sv
rtl/kmd_core.sv
rtl/key_matrix_debouncer.sv
dv/tb_key_matrix_debouncer.sv
